// File: rtl/core/pba_pkg.sv
package pba_pkg;

  // Default number of pages held in the used map.
  localparam int MAX_PAGES_DEF = 4096;

  // Bits per map word; the allocator examines one word per cycle.
  localparam int WORD_W = 128;

  // Width of the configuration registers and of the used-page count.
  localparam int CFG_W = 13;

  // Address arithmetic: pages are 4 KiB and the map starts at 1 MiB.
  localparam int PAGE_SHIFT = 12;
  localparam int LOW_PAGES  = 256;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] PAGE_COUNT_RST    = 13'd4096;
  localparam logic [CFG_W-1:0] RESERVED_LAST_RST = 13'd0;

  // Operation codes carried on the input tuser.
  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  // Configuration register indexes.
  typedef enum logic {
    REG_PAGE_COUNT    = 1'b0,
    REG_RESERVED_LAST = 1'b1
  } reg_idx_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FREE,
    ST_COMMIT
  } pba_state_t;

endpackage

// File: rtl/core/pba_map_ram.sv
module pba_map_ram #(
  parameter int WORD_W = pba_pkg::WORD_W,
  parameter int DEPTH  = 32,
  parameter int AW     = 5
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_r;

  // Single write port, single registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/page_bitmap_allocator_core.sv
// Page bitmap allocator: one used bit per 4 KiB page above 1 MiB, in 128-bit map words.
// Allocate scans one map word per cycle until it finds a free page or reaches the last word,
// reading at most ceil(page_count / 128) words, 32 at the default size.
// Free reads, modifies and commits a map word; re-initialise sweeps all WORDS words, then commits.
// One item at a time; the next item is accepted while a result waits on the output.
// Reset is synchronous; afterwards a clearing pass over all WORDS map words runs before
// the first item is accepted, leaving page zero used and all other pages free.
module page_bitmap_allocator_core #(
  parameter int MAX_PAGES = pba_pkg::MAX_PAGES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] free_address
  input  logic [1:0]  in_tuser,   // [1:0] operation
  // Result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [31:0] page_address, [32] ok, [45:33] used_pages, zero pad
  // Configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int WORD_W = pba_pkg::WORD_W;
  localparam int LOG_W  = $clog2(WORD_W);
  localparam int CFG_W  = pba_pkg::CFG_W;
  localparam int WORDS  = (MAX_PAGES + WORD_W - 1) / WORD_W;
  localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int PW     = $clog2(MAX_PAGES);
  localparam int NW     = $clog2(MAX_PAGES + 1);
  localparam int CW     = (NW > 20) ? NW : 20;
  localparam logic [AW-1:0]     LAST_WORD = AW'(WORDS - 1);
  localparam logic [WORD_W-1:0] ONES      = {WORD_W{1'b1}};

  typedef struct packed {
    logic             hit;
    logic [LOG_W-1:0] pos;
  } ffz_t;

  // Lowest set bit of a vector.
  function automatic ffz_t first_set(input logic [WORD_W-1:0] v);
    ffz_t r;
    r.hit = 1'b0;
    r.pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        r.hit = 1'b1;
        r.pos = LOG_W'(i);
      end
    end
    return r;
  endfunction

  pba_pkg::pba_state_t state_r, state_nxt;

  logic [CFG_W-1:0]  page_count_r, reserved_last_r, used_total_r;
  logic [AW-1:0]     chk_addr_r;
  logic [PW-1:0]     fr_idx_r;
  logic              cm_we_r, cm_ok_r;
  logic [AW-1:0]     cm_addr_r;
  logic [WORD_W-1:0] cm_data_r;
  logic [31:0]       cm_page_r;
  logic [CFG_W-1:0]  cm_total_r;
  logic [AW-1:0]     sw_addr_r;
  logic [PW-1:0]     sw_last_r;
  logic              sw_en_r, sw_reply_r;
  logic              out_valid_r, out_ok_r;
  logic [31:0]       out_page_r;
  logic [CFG_W-1:0]  out_used_r;

  logic              mem_we, mem_re, commit_fire, in_fire, cfg_wr;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata, mem_rdata;
  pba_pkg::op_t      in_op;

  // Number of tracked pages and the last tracked page.
  logic [CW-1:0]    n_trk, n_m1;
  logic             n_zero;
  logic [PW-1:0]    last_idx_n;
  logic [AW-1:0]    lw_n;
  logic [LOG_W-1:0] lb_n;

  assign n_trk      = (CW'(page_count_r) < CW'(MAX_PAGES)) ? CW'(page_count_r) : CW'(MAX_PAGES);
  assign n_zero     = (n_trk == '0);
  assign n_m1       = n_trk - CW'(1);
  assign last_idx_n = PW'(n_m1);
  assign lw_n       = AW'(last_idx_n >> LOG_W);
  assign lb_n       = LOG_W'(last_idx_n);

  // Free address decode: drop the offset, subtract the 1 MiB base, check the range.
  logic [19:0]   fr_page, fr_idx20;
  logic          fr_in_range;
  logic [PW-1:0] fr_idx;

  assign fr_page     = in_tdata[31:pba_pkg::PAGE_SHIFT];
  assign fr_idx20    = fr_page - 20'(pba_pkg::LOW_PAGES);
  assign fr_in_range = (in_tdata[31:20] != '0) && (CW'(fr_idx20) < n_trk);
  assign fr_idx      = PW'(fr_idx20);

  // Reserved range for re-initialise, clipped to the tracked pages.
  logic [CW-1:0] res_w, res_last;
  assign res_w    = CW'(reserved_last_r);
  assign res_last = (res_w < n_m1) ? res_w : n_m1;

  // Map word written by the clearing sweep.
  logic [AW-1:0]     sw_lw;
  logic [LOG_W-1:0]  sw_lb;
  logic [WORD_W-1:0] sweep_word;

  assign sw_lw = AW'(sw_last_r >> LOG_W);
  assign sw_lb = LOG_W'(sw_last_r);

  always_comb begin
    if (!sw_en_r || sw_addr_r > sw_lw) begin
      sweep_word = '0;
    end else if (sw_addr_r < sw_lw) begin
      sweep_word = ONES;
    end else begin
      sweep_word = ONES >> (~sw_lb);
    end
  end

  // First free page in the word under examination.
  logic [WORD_W-1:0] scan_mask;
  ffz_t              scan_ffz;
  logic              scan_last;

  assign scan_last = (chk_addr_r == lw_n);
  assign scan_mask = scan_last ? (ONES >> (~lb_n)) : ONES;
  assign scan_ffz  = first_set(~mem_rdata & scan_mask);

  logic [31:0] scan_idx;
  assign scan_idx = (32'(chk_addr_r) << LOG_W) | 32'(scan_ffz.pos);

  logic fr_bit;
  assign fr_bit = mem_rdata[LOG_W'(fr_idx_r)];

  assign in_op   = pba_pkg::op_t'(in_tuser);
  assign in_fire = in_tvalid && in_tready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pba_pkg::ST_CLEAR: begin
        if (sw_addr_r == LAST_WORD) begin
          state_nxt = sw_reply_r ? pba_pkg::ST_COMMIT : pba_pkg::ST_IDLE;
        end
      end
      pba_pkg::ST_IDLE: begin
        if (in_fire) begin
          unique case (in_op)
            pba_pkg::OP_ALLOC: state_nxt = n_zero ? pba_pkg::ST_COMMIT : pba_pkg::ST_SCAN;
            pba_pkg::OP_FREE:  state_nxt = fr_in_range ? pba_pkg::ST_FREE : pba_pkg::ST_COMMIT;
            pba_pkg::OP_INIT:  state_nxt = pba_pkg::ST_CLEAR;
            default:           state_nxt = pba_pkg::ST_COMMIT;
          endcase
        end
      end
      pba_pkg::ST_SCAN: begin
        if (scan_ffz.hit || scan_last) begin
          state_nxt = pba_pkg::ST_COMMIT;
        end
      end
      pba_pkg::ST_FREE: state_nxt = pba_pkg::ST_COMMIT;
      pba_pkg::ST_COMMIT: begin
        if (commit_fire) begin
          state_nxt = pba_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pba_pkg::ST_IDLE;
    endcase
  end

  // Memory control and handshake outputs.
  always_comb begin
    in_tready   = 1'b0;
    commit_fire = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = cm_addr_r;
    mem_wdata   = cm_data_r;
    mem_re      = 1'b0;
    mem_raddr   = chk_addr_r + AW'(1);
    unique case (state_r)
      pba_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sw_addr_r;
        mem_wdata = sweep_word;
      end
      pba_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        mem_re    = in_tvalid && ((in_op == pba_pkg::OP_ALLOC && !n_zero) ||
                                  (in_op == pba_pkg::OP_FREE && fr_in_range));
        mem_raddr = (in_op == pba_pkg::OP_ALLOC) ? '0 : AW'(fr_idx >> LOG_W);
      end
      pba_pkg::ST_SCAN: begin
        mem_re = !scan_ffz.hit && !scan_last;
      end
      pba_pkg::ST_COMMIT: begin
        commit_fire = !out_valid_r || out_tready;
        mem_we      = commit_fire && cm_we_r;
      end
      default: begin
      end
    endcase
  end

  // Sequencer datapath and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pba_pkg::ST_CLEAR;
      sw_addr_r    <= '0;
      sw_last_r    <= '0;
      sw_en_r      <= 1'b1;
      sw_reply_r   <= 1'b0;
      used_total_r <= CFG_W'(1);
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (state_r == pba_pkg::ST_CLEAR) begin
        sw_addr_r <= sw_addr_r + AW'(1);
      end

      // Accept: set the default result and prepare the operation.
      if (in_fire) begin
        cm_we_r    <= 1'b0;
        cm_page_r  <= '0;
        chk_addr_r <= '0;
        fr_idx_r   <= fr_idx;
        if (in_op == pba_pkg::OP_FREE) begin
          cm_ok_r <= fr_in_range;
        end else if (in_op == pba_pkg::OP_INIT) begin
          cm_ok_r <= 1'b1;
        end else begin
          cm_ok_r <= 1'b0;
        end
        if (in_op == pba_pkg::OP_INIT) begin
          cm_total_r <= n_zero ? '0 : CFG_W'(res_last + CW'(1));
          sw_addr_r  <= '0;
          sw_en_r    <= !n_zero;
          sw_last_r  <= PW'(res_last);
          sw_reply_r <= 1'b1;
        end else begin
          cm_total_r <= used_total_r;
        end
      end

      // Scan: one map word per cycle until a free page or the last word.
      if (state_r == pba_pkg::ST_SCAN) begin
        chk_addr_r <= chk_addr_r + AW'(1);
        if (scan_ffz.hit) begin
          cm_we_r    <= 1'b1;
          cm_addr_r  <= chk_addr_r;
          cm_data_r  <= mem_rdata | (WORD_W'(1) << scan_ffz.pos);
          cm_ok_r    <= 1'b1;
          cm_page_r  <= (scan_idx + 32'(pba_pkg::LOW_PAGES)) << pba_pkg::PAGE_SHIFT;
          cm_total_r <= used_total_r + CFG_W'(1);
        end
      end

      // Free: clear the bit and count it only if it was set.
      if (state_r == pba_pkg::ST_FREE) begin
        cm_we_r    <= 1'b1;
        cm_addr_r  <= AW'(fr_idx_r >> LOG_W);
        cm_data_r  <= mem_rdata & ~(WORD_W'(1) << LOG_W'(fr_idx_r));
        cm_total_r <= fr_bit ? (used_total_r - CFG_W'(1)) : used_total_r;
      end

      // Commit: update the count and load the result register.
      if (commit_fire) begin
        used_total_r <= cm_total_r;
        out_page_r   <= cm_page_r;
        out_ok_r     <= cm_ok_r;
        out_used_r   <= cm_total_r;
        out_valid_r  <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_used_r, out_ok_r, out_page_r};

  pba_map_ram #(
    .WORD_W (WORD_W),
    .DEPTH  (WORDS),
    .AW     (AW)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Configuration registers.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_count_r    <= pba_pkg::PAGE_COUNT_RST;
      reserved_last_r <= pba_pkg::RESERVED_LAST_RST;
    end else if (cfg_wr) begin
      unique case (pba_pkg::reg_idx_t'(cfg_paddr[2]))
        pba_pkg::REG_PAGE_COUNT:    page_count_r    <= cfg_pwdata[CFG_W-1:0];
        pba_pkg::REG_RESERVED_LAST: reserved_last_r <= cfg_pwdata[CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (pba_pkg::reg_idx_t'(cfg_paddr[2]))
      pba_pkg::REG_PAGE_COUNT:    cfg_prdata = 32'(page_count_r);
      pba_pkg::REG_RESERVED_LAST: cfg_prdata = 32'(reserved_last_r);
      default:                    cfg_prdata = '0;
    endcase
  end

`ifndef SYNTHESIS
  // One item at a time: an accepted item closes the input until its result is committed.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("input accepted while an item is in progress");

  // The free check always works on a word that was read in the cycle before.
  a_free_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pba_pkg::ST_FREE) |-> $past(mem_re))
    else $error("free check without a map read");

  // A successful allocation adds exactly one page to the count being committed.
  a_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pba_pkg::ST_SCAN && scan_ffz.hit) |=>
      (cm_total_r == used_total_r + CFG_W'(1)))
    else $error("allocation count mismatch");
`endif

endmodule

// File: verif/tb_page_bitmap_allocator_core.sv
`timescale 1ns / 1ps

// One result word as it leaves the allocator.
typedef struct packed {
  logic [31:0] page_address;
  logic        ok;
  logic [12:0] used_pages;
} page_outcome_t;

// Tracks the used map and the two registers, and predicts the result of every request.
class page_map_tracker;
  bit [pba_pkg::MAX_PAGES_DEF-1:0] used_map;
  int unsigned used_total;
  int unsigned page_count;
  int unsigned reserved_last;
  page_outcome_t outcome_q[$];
  int unsigned errors, checked;
  int unsigned grants, refusals, frees_taken, frees_ignored, map_resets, idle_codes, reg_writes;

  function new();
    used_map = '0;
    used_map[0] = 1'b1;
    used_total = 1;
    page_count = pba_pkg::PAGE_COUNT_RST;
    reserved_last = pba_pkg::RESERVED_LAST_RST;
  endfunction

  function int unsigned tracked_pages();
    return (page_count < pba_pkg::MAX_PAGES_DEF) ? page_count : pba_pkg::MAX_PAGES_DEF;
  endfunction

  function void complain(string msg);
    errors++;
    if (errors <= 10) $display("%0t ns: mismatch: %s", $time, msg);
  endfunction

  function void write_register(pba_pkg::reg_idx_t r, logic [31:0] value);
    reg_writes++;
    if (r == pba_pkg::REG_PAGE_COUNT) page_count = value & 32'h1FFF;
    else reserved_last = value & 32'h1FFF;
  endfunction

  function logic [31:0] register_value(pba_pkg::reg_idx_t r);
    return (r == pba_pkg::REG_PAGE_COUNT) ? page_count : reserved_last;
  endfunction

  // Applies one accepted request to the map and queues the result it must produce.
  function void apply_request(pba_pkg::op_t op, logic [31:0] addr);
    int unsigned n, idx;
    page_outcome_t res;
    n = tracked_pages();
    res = '0;
    case (op)
      pba_pkg::OP_ALLOC: begin
        for (int i = 0; i < n; i++) begin
          if (!used_map[i]) begin
            used_map[i] = 1'b1;
            used_total++;
            res.page_address = (i + pba_pkg::LOW_PAGES) << pba_pkg::PAGE_SHIFT;
            res.ok = 1'b1;
            break;
          end
        end
        if (res.ok) grants++;
        else refusals++;
      end
      pba_pkg::OP_FREE: begin
        // Addresses under 1 MiB or past the tracked pages are dropped.
        if (addr >= (pba_pkg::LOW_PAGES << pba_pkg::PAGE_SHIFT)) begin
          idx = (addr >> pba_pkg::PAGE_SHIFT) - pba_pkg::LOW_PAGES;
          if (idx < n) begin
            res.ok = 1'b1;
            if (used_map[idx]) begin
              used_map[idx] = 1'b0;
              used_total--;
            end
          end
        end
        if (res.ok) frees_taken++;
        else frees_ignored++;
      end
      pba_pkg::OP_INIT: begin
        // The reserved range is clipped to the tracked pages.
        used_map = '0;
        used_total = 0;
        for (int i = 0; i <= reserved_last && i < n; i++) begin
          used_map[i] = 1'b1;
          used_total++;
        end
        res.ok = 1'b1;
        map_resets++;
      end
      default: idle_codes++;
    endcase
    res.used_pages = 13'(used_total);
    outcome_q.push_back(res);
  endfunction

  // Compares one result word with the oldest prediction.
  function void compare_outcome(logic [47:0] beat);
    page_outcome_t got, want;
    got.page_address = beat[31:0];
    got.ok = beat[32];
    got.used_pages = beat[45:33];
    if (outcome_q.size() == 0) begin
      complain($sformatf("result with no request waiting: addr=%h ok=%0d used=%0d",
                         got.page_address, got.ok, got.used_pages));
      return;
    end
    want = outcome_q.pop_front();
    checked++;
    if (got.page_address !== want.page_address || got.ok !== want.ok ||
        got.used_pages !== want.used_pages)
      complain($sformatf("result %0d: expected addr=%h ok=%0d used=%0d, got addr=%h ok=%0d used=%0d",
                         checked, want.page_address, want.ok, want.used_pages,
                         got.page_address, got.ok, got.used_pages));
  endfunction
endclass

module tb_page_bitmap_allocator_core;

  localparam int STALL_LIMIT = 2000;
  localparam logic [31:0] LOW_LIMIT = pba_pkg::LOW_PAGES << pba_pkg::PAGE_SHIFT;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [1:0]  in_tuser = pba_pkg::OP_NOP;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  page_map_tracker tracker;
  bit          calm = 1'b0;
  int unsigned idle_cycles = 0;

  page_bitmap_allocator_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #10 clk = ~clk;

  function automatic bit stall_roll();
    return !calm && ($urandom_range(0, 99) < 23);
  endfunction

  // The result side stalls at random except during a calm stretch.
  always @(negedge clk) begin
    out_tready <= !stall_roll();
  end

  // Every result word is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.compare_outcome(out_tdata);
  end

  // The run is stopped when no handshake of any kind happens for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Presents one request and holds it until the allocator takes it.
  task automatic send_item(pba_pkg::op_t op, logic [31:0] addr);
    while (stall_roll()) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= addr;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.apply_request(op, addr);
    @(negedge clk);
  endtask

  // Register write: setup cycle, access cycle, then the bus goes idle.
  task automatic reg_write(pba_pkg::reg_idx_t r, logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {r, 2'b00};
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    tracker.write_register(r, value);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  // Register read-back, compared with the last value written.
  task automatic reg_check(pba_pkg::reg_idx_t r);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_paddr <= {r, 2'b00};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== tracker.register_value(r))
      tracker.complain($sformatf("register %s: expected %0d, read %0d", r.name(),
                                 tracker.register_value(r), cfg_prdata));
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  // Stops sending and waits until every predicted result has come back.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (tracker.outcome_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic configure(logic [12:0] count, logic [12:0] reserved);
    settle();
    reg_write(pba_pkg::REG_PAGE_COUNT, 32'(count));
    reg_write(pba_pkg::REG_RESERVED_LAST, 32'(reserved));
    reg_check(pba_pkg::REG_PAGE_COUNT);
    reg_check(pba_pkg::REG_RESERVED_LAST);
  endtask

  function automatic pba_pkg::op_t pick_op(int unsigned alloc_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < alloc_pct) return pba_pkg::OP_ALLOC;
    if (roll < 90) return pba_pkg::OP_FREE;
    if (roll < 95) return pba_pkg::OP_INIT;
    return pba_pkg::OP_NOP;
  endfunction

  // Free addresses: nearly half in the occupied low region, most others across the tracked pages
  // (some past the count), some under 1 MiB, some anywhere; a quarter of page picks carry a page offset.
  function automatic logic [31:0] pick_free_address();
    int unsigned n, hi, idx, roll;
    logic [31:0] a;
    n = tracker.tracked_pages();
    roll = $urandom_range(0, 99);
    if (roll < 8) return $urandom;
    if (roll < 14) return $urandom_range(0, LOW_LIMIT - 1);
    hi = (roll < 60) ? tracker.used_total + 4 : n + 1;
    if (hi > n + 1) hi = n + 1;
    idx = $urandom_range(0, hi);
    a = (idx + pba_pkg::LOW_PAGES) << pba_pkg::PAGE_SHIFT;
    if ($urandom_range(0, 3) == 0) a[11:0] = 12'($urandom);
    return a;
  endfunction

  task automatic run_phase(logic [12:0] count, logic [12:0] reserved, int unsigned items,
                           int unsigned alloc_pct, bit quiet, bit start_clean);
    pba_pkg::op_t op;
    configure(count, reserved);
    calm = quiet;
    if (start_clean) send_item(pba_pkg::OP_INIT, $urandom);
    for (int i = 0; i < items; i++) begin
      op = pick_op(alloc_pct);
      send_item(op, (op == pba_pkg::OP_FREE) ? pick_free_address() : $urandom);
    end
    calm = 1'b0;
  endtask

  initial begin
    tracker = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset map, field extremes, out-of-range and unaligned frees.
    send_item(pba_pkg::OP_ALLOC, 32'h0);
    send_item(pba_pkg::OP_ALLOC, 32'hFFFF_FFFF);
    send_item(pba_pkg::OP_FREE, 32'h0010_1000);
    send_item(pba_pkg::OP_FREE, 32'h0010_1000);
    send_item(pba_pkg::OP_FREE, 32'h0000_0000);
    send_item(pba_pkg::OP_FREE, 32'h000F_FFFF);
    send_item(pba_pkg::OP_FREE, 32'h0010_2ABC);
    send_item(pba_pkg::OP_FREE, 32'hFFFF_FFFF);
    send_item(pba_pkg::OP_FREE, 32'h010F_F000);
    send_item(pba_pkg::OP_FREE, 32'h0110_0000);
    send_item(pba_pkg::OP_NOP, 32'hA5A5_5A5A);
    send_item(pba_pkg::OP_ALLOC, 32'h0);
    send_item(pba_pkg::OP_INIT, 32'h0);

    // Zero pages: nothing reserved, allocation and free both refused.
    configure(13'd0, 13'd4096);
    send_item(pba_pkg::OP_INIT, 32'h0);
    send_item(pba_pkg::OP_ALLOC, 32'h0);
    send_item(pba_pkg::OP_FREE, 32'h0010_0000);

    // Two pages: the map fills up and the next allocation fails.
    configure(13'd2, 13'd0);
    send_item(pba_pkg::OP_INIT, 32'h0);
    send_item(pba_pkg::OP_ALLOC, 32'h0);
    send_item(pba_pkg::OP_ALLOC, 32'h0);
    send_item(pba_pkg::OP_FREE, 32'h0010_1000);

    // Whole map reserved.
    configure(13'd4096, 13'd4095);
    send_item(pba_pkg::OP_INIT, 32'h0);
    send_item(pba_pkg::OP_ALLOC, 32'h0);
    send_item(pba_pkg::OP_FREE, 32'h010F_F000);

    // Random traffic across a range of map settings.
    run_phase(13'd4096, 13'd0,    150, 55, 1'b0, 1'b1);
    run_phase(13'd8,    13'd0,    100, 50, 1'b0, 1'b1);
    run_phase(13'd130,  13'd5,    150, 60, 1'b0, 1'b1);
    run_phase(13'd4096, 13'd4000, 150, 60, 1'b0, 1'b1);
    run_phase(13'd8191, 13'd8191,  80, 40, 1'b0, 1'b1);
    run_phase(13'd1,    13'd0,     60, 50, 1'b0, 1'b1);
    run_phase(13'd257,  13'd300,  100, 55, 1'b0, 1'b1);
    run_phase(13'd40,   13'd39,   100, 50, 1'b0, 1'b1);
    run_phase(13'd600,  13'd127,  200, 55, 1'b1, 1'b1);
    // Shrink the count over a busy map without clearing it.
    run_phase(13'd20,   13'd127,   80, 45, 1'b0, 1'b0);
    run_phase(13'd0,    13'd10,    40, 50, 1'b0, 1'b1);

    settle();
    repeat (40) @(posedge clk);
    if (tracker.outcome_q.size() != 0)
      tracker.complain($sformatf("%0d results never arrived", tracker.outcome_q.size()));

    $display("Checked %0d results: %0d pages granted, %0d allocations refused, %0d frees taken,",
             tracker.checked, tracker.grants, tracker.refusals, tracker.frees_taken);
    $display("%0d frees ignored, %0d map resets, %0d idle codes, %0d register writes.",
             tracker.frees_ignored, tracker.map_resets, tracker.idle_codes, tracker.reg_writes);
    if (tracker.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches in total", tracker.errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/pba_pkg.sv
rtl/core/pba_map_ram.sv
rtl/core/page_bitmap_allocator_core.sv
verif/tb_page_bitmap_allocator_core.sv
